// File: hw/rtl/ascii85_z85_encoder_assert.svh
// Assertion macros used by the encoder back end.
`ifndef ASCII85_Z85_ENCODER_ASSERT_SVH
`define ASCII85_Z85_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define A85Z_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define A85Z_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/a85z_pkg.sv
// Shared types, constants and character mapping for the Ascii85 / Z85 encoder.
`default_nettype none

package a85z_pkg;

  // Configuration port
  localparam int unsigned CfgIndexWidth = 2;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgAlphabetSelect   = 2'd0,
    CfgZeroAbbrevEnable = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic alphabet_select;
    logic zero_abbrev_enable;
  } cfg_t;

  // Group queue depth default
  localparam int unsigned QueueDepthDefault = 2;

  // One group handed from front to back
  typedef struct packed {
    logic [31:0] val;
    logic [2:0]  count;
    logic        zero;
    logic        last;
  } grp_t;

  // Fixed-point base-85 conversion: frac = val * Recip / 2^FracBits
  localparam int unsigned FracBits  = 65;
  localparam logic [71:0] Pow85Five = 72'd85 * 72'd85 * 72'd85 * 72'd85 * 72'd85;
  localparam logic [71:0] RecipWide = ((72'd1 << FracBits) + Pow85Five - 72'd1) / Pow85Five;
  localparam logic [32:0] Recip     = RecipWide[32:0];

  localparam logic [7:0] CharZ     = 8'h7A;
  localparam logic [7:0] AsciiBase = 8'd33;
  localparam logic [6:0] DigitMax  = 7'd84;

  localparam logic [8*85-1:0] Z85Chars =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  // Map one base-85 digit to its character
  function automatic logic [7:0] map_digit(input logic [6:0] digit, input logic z85);
    logic [6:0] d;
    logic [9:0] pos;
    begin
      d   = (digit > DigitMax) ? DigitMax : digit;
      pos = {3'd0, 7'(DigitMax - d)} << 3;
      if (z85) begin
        return Z85Chars[pos +: 8];
      end else begin
        return AsciiBase + {1'b0, d};
      end
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/a85z_if.sv
// Handshake channel interfaces: raw bytes, encoded characters, register writes.
`default_nettype none

interface a85z_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface a85z_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       stream_last;

  modport source (output valid, output out_char, output run_last, output stream_last,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input stream_last,
                  output ready);
endinterface

interface a85z_cfg_if import a85z_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/a85z_front.sv
// Front end: gathers bytes into groups and classifies each finished group.
`default_nettype none

module a85z_front import a85z_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  a85z_byte_if.sink    raw,
  input  wire cfg_t    cfg_regs,
  output logic         push_valid,
  output grp_t         push_data,
  input  wire logic    push_ready
);

  logic [23:0] acc;
  logic [1:0]  held;
  logic        accept;
  logic        complete;
  logic [31:0] val;
  logic        zero;

  assign raw.ready = push_ready;
  assign accept    = raw.valid && raw.ready;
  assign complete  = (held == 2'd3) || raw.end_of_data;

  // Left-justify the held bytes plus this one, zero padded
  always_comb begin
    unique case (held)
      2'd0:    val = {raw.data_byte, 24'd0};
      2'd1:    val = {acc[7:0], raw.data_byte, 16'd0};
      2'd2:    val = {acc[15:0], raw.data_byte, 8'd0};
      default: val = {acc, raw.data_byte};
    endcase
  end

  // Classify: abbreviate only an all-zero full group
  assign zero = (held == 2'd3) && (val == 32'd0) && cfg_regs.zero_abbrev_enable;

  always_comb begin
    push_valid     = accept && complete;
    push_data.val  = val;
    push_data.zero = zero;
    push_data.last = raw.end_of_data;
    if (zero) begin
      push_data.count = 3'd1;
    end else if (held == 2'd3) begin
      push_data.count = 3'd5;
    end else begin
      push_data.count = {1'b0, held} + 3'd2;
    end
  end

  // Hold bytes until the group completes, then drop back to empty
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      held <= '0;
    end else if (accept) begin
      if (complete) begin
        acc  <= '0;
        held <= '0;
      end else begin
        acc  <= {acc[15:0], raw.data_byte};
        held <= held + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/a85z_fifo.sv
// Short group queue between the front and back ends.
`default_nettype none

module a85z_fifo import a85z_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  input  wire grp_t push_data,
  output logic      push_ready,
  output logic      pop_valid,
  output grp_t      pop_data,
  input  wire logic pop_ready
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  grp_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            push;
  logic            pop;

  assign push_ready = (fill != CntW'(Depth));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Store a group at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/a85z_back.sv
// Back end: base-85 digit extraction, character mapping and output register.
`default_nettype none

`include "ascii85_z85_encoder_assert.svh"

module a85z_back import a85z_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    pop_valid,
  input  wire grp_t    pop_data,
  output logic         pop_ready,
  input  wire cfg_t    cfg_regs,
  a85z_char_if.source  enc
);

  typedef struct packed {
    logic [2:0] count;
    logic       zero;
    logic       last;
  } meta_t;

  // Multiply stage
  logic        m_valid;
  logic [64:0] m_prod;
  meta_t       m_meta;
  logic [64:0] prod;
  logic        m_take;

  // Digit stage
  logic        e_valid;
  logic [64:0] e_frac;
  logic [2:0]  e_left;
  logic        e_zero;
  logic        e_last;
  logic [71:0] scaled;
  logic [6:0]  digit;
  logic        emit;
  logic        e_done;

  // Output register
  logic        o_valid;
  logic [7:0]  o_char;
  logic        o_run_last;
  logic        o_stream_last;
  logic        o_free;

  assign o_free = !o_valid || enc.ready;
  assign emit   = e_valid && o_free;
  assign e_done = emit && (e_left == 3'd1);
  assign m_take = m_valid && (!e_valid || e_done);
  assign pop_ready = !m_valid || m_take;

  // Scale the group into a base-85 fraction
  assign prod = {33'd0, pop_data.val} * {32'd0, Recip};

  // Next digit: multiply the fraction by 85, integer part is the digit
  assign scaled = ({7'd0, e_frac} << 6) + ({7'd0, e_frac} << 4)
                + ({7'd0, e_frac} << 2) + {7'd0, e_frac};
  assign digit  = scaled[71:65];

  // Multiply stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (pop_ready) begin
      m_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      m_prod       <= prod;
      m_meta.count <= pop_data.count;
      m_meta.zero  <= pop_data.zero;
      m_meta.last  <= pop_data.last;
    end
  end

  // Digit stage: load a group, then emit one character per beat while the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      e_left  <= '0;
    end else if (m_take) begin
      e_valid <= 1'b1;
      e_left  <= m_meta.count;
    end else if (emit) begin
      e_valid <= (e_left != 3'd1);
      e_left  <= e_left - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_take) begin
      e_frac <= m_prod;
      e_zero <= m_meta.zero;
      e_last <= m_meta.last;
    end else if (emit) begin
      e_frac <= scaled[64:0];
    end
  end

  // Output register: hold while stalled, refill while draining
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (enc.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_char        <= e_zero ? CharZ : map_digit(digit, cfg_regs.alphabet_select);
      o_run_last    <= (e_left == 3'd1);
      o_stream_last <= (e_left == 3'd1) && e_last;
    end
  end

  assign enc.valid       = o_valid;
  assign enc.out_char    = o_char;
  assign enc.run_last    = o_run_last;
  assign enc.stream_last = o_stream_last;

  `A85Z_ASSERT_NOW(a_left_range, clk, rst, e_valid, e_left != 3'd0 && e_left <= 3'd5, "digit stage holds a bad character count")
  `A85Z_ASSERT_NOW(a_digit_range, clk, rst, e_valid && !e_zero, digit <= DigitMax, "base-85 digit out of range")
  `A85Z_ASSERT_NEXT(a_zero_single, clk, rst, m_take && m_meta.zero, e_valid && e_left == 3'd1, "zero group must give a single character")
  `A85Z_ASSERT_NEXT(a_run_end, clk, rst, e_done, o_valid && o_run_last, "last character of a group lost its run mark")

endmodule

`default_nettype wire

// File: hw/rtl/ascii85_z85_encoder.sv
// Top level of the byte-serial Ascii85 / Z85 encoder.
`default_nettype none

// Bytes enter on raw, one per beat; every fourth byte, or a byte marked
// end_of_data, closes a group that becomes up to five characters on enc,
// most significant digit first. A full group gives five characters (or a
// single 'z' when it is all zero and abbreviation is enabled); a final
// partial group of n bytes gives n+1. While enc is ready, the digit stage
// emits one character per clock, so sustained throughput is one character
// per cycle; the front takes a byte every cycle while the group queue has
// room. A byte that closes a group passes the group queue, the multiply
// stage register, the digit stage and the output register before its
// first character shows on enc. Register writes on cfg are always taken and
// belong in idle periods: index 0 selects the Z85 alphabet, index 1
// enables the zero abbreviation; other indexes are ignored.
module ascii85_z85_encoder import a85z_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic    clk,
  input  wire logic    rst,
  a85z_byte_if.sink    raw,
  a85z_char_if.source  enc,
  a85z_cfg_if.sink     cfg
);

  cfg_t cfg_regs;
  logic push_valid;
  grp_t push_data;
  logic push_ready;
  logic pop_valid;
  grp_t pop_data;
  logic pop_ready;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.alphabet_select    <= 1'b0;
      cfg_regs.zero_abbrev_enable <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CfgAlphabetSelect:   cfg_regs.alphabet_select    <= cfg.data;
        CfgZeroAbbrevEnable: cfg_regs.zero_abbrev_enable <= cfg.data;
        default: ;
      endcase
    end
  end

  a85z_front u_front (
    .clk        (clk),
    .rst        (rst),
    .raw        (raw),
    .cfg_regs   (cfg_regs),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  a85z_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  a85z_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .cfg_regs  (cfg_regs),
    .enc       (enc)
  );

endmodule

`default_nettype wire
